@@ rtl/core/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding window maximum package
// Shared widths, transaction types and the control word of the cell row.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WindowMax = 64;
  localparam int DataW     = 32;
  localparam int MaxAgeW   = 6;
  localparam int CfgW      = 7;
  localparam int CountW    = $clog2(WindowMax + 1);
  localparam int AgeW      = CountW;
  localparam int AddrW     = 3;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic                    start_req;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] window_max;
    logic [MaxAgeW-1:0]      max_age;
  } out_item_t;

  typedef struct packed {
    logic                    clear;
    logic                    age_inc;
    logic                    shift;
    logic                    push;
    logic signed [DataW-1:0] sample;
  } cell_ctrl_t;

endpackage

@@ rtl/core/swm_cell.sv @@
// ----------------------------------------------------------------------------
// Sliding window maximum cell
// One entry of the candidate queue: it ages, takes its back-side neighbor
// on a front pop, drops out when dominated and captures an appended sample.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  swm_pkg::cell_ctrl_t                     ctrl_i,
  input  logic                                    prev_keep_i,
  input  logic                                    next_valid_i,
  input  logic signed [swm_pkg::DataW-1:0]        next_value_i,
  input  logic [swm_pkg::AgeW-1:0]                next_age_i,
  output logic                                    valid_o,
  output logic signed [swm_pkg::DataW-1:0]        value_o,
  output logic [swm_pkg::AgeW-1:0]                age_o,
  output logic                                    keep_o
);

  logic                             valid_q, valid_d;
  logic signed [swm_pkg::DataW-1:0] value_q, value_d;
  logic [swm_pkg::AgeW-1:0]         age_q, age_d;
  logic                             dominated;
  logic                             keep;
  logic                             take;

  assign dominated = valid_q && (value_q <= ctrl_i.sample);
  assign keep      = valid_q && !dominated;
  assign take      = !keep && prev_keep_i;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    age_d   = age_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.age_inc) begin
      age_d = age_q + swm_pkg::AgeW'(1);
    end else if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      value_d = next_value_i;
      age_d   = next_age_i;
    end else if (ctrl_i.push) begin
      valid_d = keep || take;
      if (take) begin
        value_d = ctrl_i.sample;
        age_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    age_q   <= age_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign age_o   = age_q;
  assign keep_o  = keep;

endmodule

@@ rtl/core/sliding_window_maximum.sv @@
// ----------------------------------------------------------------------------
// Sliding window maximum
// Running maximum filter over the last window_size signed samples, built as a
// row of queue cells with the current maximum always in the first cell.
// ----------------------------------------------------------------------------
// A sample transaction is accepted in StIdle, which ages every candidate;
// StWork then retires the candidates it dominates and appends it to the
// queue. Each candidate that leaves the window at the front is first taken
// out by a one-step shift of the cell row in StWork.
// in_stall_o is high while an item is in work. No result is given until
// window_size samples of the current sequence have arrived; start_req begins
// a new sequence. A result waiting in the output register holds the queue
// update back until it is taken.
module sliding_window_maximum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  swm_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output swm_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swm_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  typedef enum logic {
    StIdle,
    StWork
  } state_e;

  localparam logic RegWindowSize = 1'b0;

  state_e                            state_q;
  logic signed [swm_pkg::DataW-1:0]  sample_q;
  logic [swm_pkg::CountW-1:0]        fill_q;
  logic [swm_pkg::CfgW-1:0]          win_size_q;
  logic                              out_valid_q;
  swm_pkg::out_item_t                out_data_q;

  logic                              in_accept;
  logic                              cfg_write;
  logic [swm_pkg::CountW-1:0]        win_eff;
  logic [swm_pkg::CountW-1:0]        fill_inc;
  logic                              front_expired;
  logic                              out_free;
  logic                              do_push;
  logic                              out_emit;
  swm_pkg::cell_ctrl_t               ctrl;

  logic                              valid_w [swm_pkg::WindowMax];
  logic signed [swm_pkg::DataW-1:0]  value_w [swm_pkg::WindowMax];
  logic [swm_pkg::AgeW-1:0]          age_w   [swm_pkg::WindowMax];
  logic                              keep_w  [swm_pkg::WindowMax];

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegWindowSize);
  assign prdata    = (paddr[2] == RegWindowSize) ? 32'(win_size_q) : 32'd0;

  always_comb begin
    if (win_size_q == '0) begin
      win_eff = swm_pkg::CountW'(1);
    end else if (swm_pkg::CountW'(win_size_q) > swm_pkg::CountW'(swm_pkg::WindowMax)) begin
      win_eff = swm_pkg::CountW'(swm_pkg::WindowMax);
    end else begin
      win_eff = swm_pkg::CountW'(win_size_q);
    end
  end

  assign fill_inc = (fill_q == swm_pkg::CountW'(swm_pkg::WindowMax)) ? fill_q
                    : fill_q + swm_pkg::CountW'(1);

  assign front_expired = valid_w[0] && (age_w[0] >= win_eff);
  assign out_free      = !out_valid_q || !out_stall_i;
  assign do_push       = (state_q == StWork) && !front_expired && out_free;
  assign out_emit      = do_push && (fill_inc >= win_eff);

  always_comb begin
    ctrl.clear   = in_accept && in_data_i.start_req;
    ctrl.age_inc = in_accept;
    ctrl.shift   = (state_q == StWork) && front_expired;
    ctrl.push    = do_push;
    ctrl.sample  = sample_q;
  end

  for (genvar k = 0; k < swm_pkg::WindowMax; k++) begin : g_cell
    logic                             prev_keep;
    logic                             next_valid;
    logic signed [swm_pkg::DataW-1:0] next_value;
    logic [swm_pkg::AgeW-1:0]         next_age;

    if (k == 0) begin : g_first
      assign prev_keep = 1'b1;
    end else begin : g_inner
      assign prev_keep = keep_w[k-1];
    end

    if (k == swm_pkg::WindowMax - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_value = '0;
      assign next_age   = '0;
    end else begin : g_body
      assign next_valid = valid_w[k+1];
      assign next_value = value_w[k+1];
      assign next_age   = age_w[k+1];
    end

    swm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_keep_i  (prev_keep),
      .next_valid_i (next_valid),
      .next_value_i (next_value),
      .next_age_i   (next_age),
      .valid_o      (valid_w[k]),
      .value_o      (value_w[k]),
      .age_o        (age_w[k]),
      .keep_o       (keep_w[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sample_q    <= '0;
      fill_q      <= '0;
      win_size_q  <= swm_pkg::CfgW'(1);
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_write) begin
        win_size_q <= pwdata[swm_pkg::CfgW-1:0];
      end
      if (out_emit) begin
        out_valid_q <= 1'b1;
        if (keep_w[0]) begin
          out_data_q.window_max <= value_w[0];
          out_data_q.max_age    <= swm_pkg::MaxAgeW'(age_w[0]);
        end else begin
          out_data_q.window_max <= sample_q;
          out_data_q.max_age    <= '0;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_accept) begin
            sample_q <= in_data_i.sample;
            if (in_data_i.start_req) begin
              fill_q <= '0;
            end
            state_q <= StWork;
          end
        end
        StWork: begin
          if (do_push) begin
            fill_q  <= fill_inc;
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Sliding window maximum testbench
// Drives signed samples through the filter under random source gaps and sink
// stalls; checks each result against a local candidate queue model or the
// typed result of its directed row. The window size register is written and
// read back between phases: zero, one, the largest window, saturating values.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CycleLimit  = 1_000_000;
  localparam int RandomItems = 950;
  localparam int SettleCycles = swm_pkg::WindowMax + 8;
  localparam logic [swm_pkg::AddrW-1:0] WindowSizeAddr = '0;

  typedef enum logic [0:0] {RowSample, RowWindow} row_kind_e;
  typedef enum int {PatWide, PatNarrow, PatFalling, PatRising, PatEdges} pattern_e;

  typedef struct packed {
    row_kind_e                        kind;
    logic [31:0]                      value;
    logic                             start;
    logic                             typed;
    logic signed [swm_pkg::DataW-1:0] max_val;
    logic [swm_pkg::MaxAgeW-1:0]      max_age;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  swm_pkg::in_item_t  in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  swm_pkg::out_item_t out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [swm_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  sliding_window_maximum dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Candidate queue of the filter: front holds the current maximum.
  logic signed [swm_pkg::DataW-1:0] cand_val [swm_pkg::WindowMax];
  int unsigned             cand_age [swm_pkg::WindowMax];
  int unsigned             cand_cnt = 0;
  int unsigned             seen_cnt = 0;
  logic [swm_pkg::CfgW-1:0] win_reg = swm_pkg::CfgW'(1);

  swm_pkg::out_item_t max_q [$];
  int unsigned error_cnt     = 0;
  int unsigned results_seen  = 0;
  int unsigned samples_sent  = 0;
  int unsigned windows_set   = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned in_gap_max    = 6;
  int unsigned out_hold_max  = 6;
  int unsigned hold_left     = 0;
  swm_pkg::out_item_t want_res;

  dir_row_t directed_rows [23] = '{
    '{RowSample, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'sh7FFF_FFFF, 6'd0},
    '{RowSample, 32'h8000_0000, 1'b0, 1'b1, 32'sh8000_0000, 6'd0},
    '{RowSample, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'shFFFF_FFFF, 6'd0},
    '{RowWindow, 32'd0,         1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'h0000_0000, 1'b0, 1'b1, 32'sh0000_0000, 6'd0},
    '{RowSample, 32'h5555_5555, 1'b0, 1'b1, 32'sh5555_5555, 6'd0},
    '{RowWindow, 32'd3,         1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'hFFFF_FFFB, 1'b1, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'hFFFF_FFF9, 1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'hFFFF_FFFA, 1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'hFFFF_FFFA, 1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'h8000_0000, 1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowWindow, 32'hFFFF_FF7F, 1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'h0000_0001, 1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowWindow, 32'd2,         1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'h0000_0000, 1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'h8000_0001, 1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowWindow, 32'd64,        1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'h7FFF_FFFE, 1'b0, 1'b0, 32'sd0,         6'd0},
    '{RowSample, 32'h8000_0000, 1'b1, 1'b0, 32'sd0,         6'd0}
  };

  task automatic note_error(input string msg);
    error_cnt++;
    if (error_cnt <= 10) $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
  endtask

  function automatic bit advance_window(input swm_pkg::in_item_t smp,
                                        output swm_pkg::out_item_t res);
    int unsigned w;
    w = (win_reg == 0) ? 1 : ((win_reg > swm_pkg::WindowMax) ? swm_pkg::WindowMax : win_reg);
    res = '0;
    if (smp.start_req) begin
      cand_cnt = 0;
      seen_cnt = 0;
    end
    for (int i = 0; i < cand_cnt; i++) cand_age[i]++;
    while (cand_cnt > 0 && cand_age[0] >= w) begin
      for (int i = 0; i + 1 < cand_cnt; i++) begin
        cand_val[i] = cand_val[i+1];
        cand_age[i] = cand_age[i+1];
      end
      cand_cnt--;
    end
    while (cand_cnt > 0 && cand_val[cand_cnt-1] <= smp.sample) cand_cnt--;
    if (cand_cnt < swm_pkg::WindowMax) begin
      cand_val[cand_cnt] = smp.sample;
      cand_age[cand_cnt] = 0;
      cand_cnt++;
    end
    if (seen_cnt < swm_pkg::WindowMax) seen_cnt++;
    if (seen_cnt < w) return 1'b0;
    res.window_max = cand_val[0];
    res.max_age    = swm_pkg::MaxAgeW'(cand_age[0]);
    return 1'b1;
  endfunction

  task automatic send_sample(input logic signed [swm_pkg::DataW-1:0] value, input logic start,
                             input logic typed, input swm_pkg::out_item_t typed_res);
    swm_pkg::in_item_t  smp;
    swm_pkg::out_item_t res;
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    smp.sample    = value;
    smp.start_req = start;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= smp;
    do @(posedge clk_i); while (in_stall_o);
    samples_sent++;
    if (advance_window(smp, res)) max_q.insert(max_q.size(), typed ? typed_res : res);
  endtask

  task automatic set_window(input logic [31:0] wr_value);
    in_valid_i <= 1'b0;
    while (max_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WindowSizeAddr;
    pwdata  <= wr_value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    win_reg = wr_value[swm_pkg::CfgW-1:0];
    windows_set++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(win_reg))
      note_error($sformatf("window_size read back %0d, expected %0d", prdata, win_reg));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic signed [swm_pkg::DataW-1:0] next_sample(
      input pattern_e pat, input logic signed [swm_pkg::DataW-1:0] last);
    int narrow;
    if ($urandom_range(0, 9) == 0) return $urandom();
    case (pat)
      PatNarrow: begin
        narrow = $urandom_range(0, 6);
        return narrow - 3;
      end
      PatFalling: return last - $urandom_range(0, 3);
      PatRising:  return last + $urandom_range(0, 3);
      PatEdges: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (max_q.size() == 0) begin
          note_error($sformatf("result with none expected: max %0d age %0d",
                               out_data_o.window_max, out_data_o.max_age));
        end else begin
          want_res = max_q[0];
          max_q.delete(0);
          if (out_data_o.window_max !== want_res.window_max ||
              out_data_o.max_age !== want_res.max_age)
            note_error($sformatf("expected max %0d age %0d, got max %0d age %0d",
                                 want_res.window_max, want_res.max_age,
                                 out_data_o.window_max, out_data_o.max_age));
        end
        hold_left = $urandom_range(0, out_hold_max);
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left != 0);
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Run exceeded %0d cycles.", CycleLimit);
    $display("sliding_window_maximum: mismatch");
    $finish;
  end

  initial begin
    swm_pkg::out_item_t typed_res;
    pattern_e    pat;
    logic [swm_pkg::CfgW-1:0] win;
    logic signed [swm_pkg::DataW-1:0] level;
    logic        start;
    int unsigned random_sent;
    int unsigned run_len;
    random_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == RowWindow) begin
        set_window(directed_rows[r].value);
      end else begin
        typed_res.window_max = directed_rows[r].max_val;
        typed_res.max_age    = directed_rows[r].max_age;
        send_sample(directed_rows[r].value, directed_rows[r].start,
                    directed_rows[r].typed, typed_res);
      end
    end

    level = $urandom();
    while (random_sent < RandomItems) begin
      case ($urandom_range(0, 9))
        0:       win = swm_pkg::CfgW'(0);
        1:       win = swm_pkg::CfgW'(1);
        2:       win = swm_pkg::CfgW'(swm_pkg::WindowMax);
        3:       win = '1;
        4, 5, 6: win = swm_pkg::CfgW'($urandom_range(2, 8));
        default: win = swm_pkg::CfgW'($urandom_range(0, 127));
      endcase
      set_window(($urandom() & ~32'h7F) | 32'(win));
      in_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 6;
      out_hold_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      pat     = pattern_e'($urandom_range(0, 4));
      run_len = (win >= 32) ? $urandom_range(60, 140) : $urandom_range(10, 60);
      for (int k = 0; k < run_len && random_sent < RandomItems; k++) begin
        start = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 39) == 0);
        level = next_sample(pat, level);
        send_sample(level, start, 1'b0, '0);
        random_sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (max_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d samples across %0d window size settings.", samples_sent, windows_set);
    $display("Compared %0d result transactions; %0d errors.", results_seen, error_cnt);
    if (error_cnt == 0) begin
      $display("sliding_window_maximum: match");
    end else begin
      $display("sliding_window_maximum: mismatch");
    end
    $finish;
  end

endmodule
